FILE: sv/assert_macros.svh
// assertion macros shared by the rtl of the nearest mate unit
// no dependencies; assertions are compiled out when ASSERT_OFF is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define GNMC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GNMC_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GNMC_ASSERT(lbl, clk, rst_n, prop, msg)
`define GNMC_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: sv/gnmc_pkg.sv
// shared types and fixed widths of the nearest mate and centroid unit
// no dependencies
`timescale 1ns / 1ps
package gnmc_pkg;
  localparam int IDX_OUT_W = 6;
  localparam int DIST_W    = 17;
  localparam int MEAN_W    = 16;
  localparam int NUM_LANES = 4;
  localparam logic [DIST_W-1:0] NO_MATE_DIST = '1;

  // bookkeeping that travels with one squared distance
  typedef struct packed {
    logic [IDX_OUT_W-1:0] member;
    logic [IDX_OUT_W-1:0] mate;
    logic                 has_mate;
    logic                 last;
  } gnmc_tag_t;
endpackage

FILE: sv/gnmc_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module gnmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: sv/gnmc_front.sv
// front end: accepts members, writes positions, keeps group sums and count
// closes a group into a job word; no package dependencies
`timescale 1ns / 1ps
module gnmc_front #(
  parameter int MAX_MEMBERS = 64,
  parameter int COORD_BITS  = 16,
  localparam int IDXW  = $clog2(MAX_MEMBERS),
  localparam int AW    = IDXW + 1,
  localparam int CNT_W = $clog2(MAX_MEMBERS + 1),
  localparam int SW    = COORD_BITS + $clog2(MAX_MEMBERS) + 1,
  localparam int JW    = 1 + CNT_W + 4 * SW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] pos_x_i,
  input  logic [COORD_BITS-1:0] pos_y_i,
  input  logic [COORD_BITS-1:0] vel_x_i,
  input  logic [COORD_BITS-1:0] vel_y_i,
  input  logic                  last_member_i,
  input  logic                  banks_full_i,
  output logic                  ram_we_o,
  output logic [AW-1:0]         ram_addr_o,
  output logic [2*COORD_BITS-1:0] ram_wdata_o,
  output logic                  job_push_o,
  output logic [JW-1:0]         job_data_o
);
  logic             bank_q, bank_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_sum;
  logic [SW-1:0]    psx_q, psy_q, vsx_q, vsy_q;
  logic [SW-1:0]    psx_d, psy_d, vsx_d, vsy_d;
  logic [SW-1:0]    psx_s, psy_s, vsx_s, vsy_s;
  logic             accept, store, close;

  function automatic logic [SW-1:0] sext(input logic [COORD_BITS-1:0] v);
    sext = {{(SW - COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  // accept, store while room, close on the last member
  always_comb begin
    accept  = in_valid_i && !banks_full_i;
    store   = accept && (cnt_q < CNT_W'(MAX_MEMBERS));
    close   = accept && last_member_i;
    cnt_sum = cnt_q + CNT_W'(store);
    psx_s   = psx_q + (store ? sext(pos_x_i) : '0);
    psy_s   = psy_q + (store ? sext(pos_y_i) : '0);
    vsx_s   = vsx_q + (store ? sext(vel_x_i) : '0);
    vsy_s   = vsy_q + (store ? sext(vel_y_i) : '0);
    bank_d  = close ? !bank_q : bank_q;
    cnt_d   = close ? '0 : cnt_sum;
    psx_d   = close ? '0 : psx_s;
    psy_d   = close ? '0 : psy_s;
    vsx_d   = close ? '0 : vsx_s;
    vsy_d   = close ? '0 : vsy_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0;
      cnt_q  <= '0;
      psx_q  <= '0;
      psy_q  <= '0;
      vsx_q  <= '0;
      vsy_q  <= '0;
    end else begin
      bank_q <= bank_d;
      cnt_q  <= cnt_d;
      psx_q  <= psx_d;
      psy_q  <= psy_d;
      vsx_q  <= vsx_d;
      vsy_q  <= vsy_d;
    end
  end

  assign in_stall_o  = banks_full_i;
  assign ram_we_o    = store;
  assign ram_addr_o  = {bank_q, cnt_q[IDXW-1:0]};
  assign ram_wdata_o = {pos_x_i, pos_y_i};
  assign job_push_o  = close;
  assign job_data_o  = {bank_q, cnt_sum, psx_s, psy_s, vsx_s, vsy_s};
endmodule

FILE: sv/gnmc_queue.sv
// two entry job queue between the front end and the back end
// no dependencies
`timescale 1ns / 1ps
module gnmc_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);
  logic [W-1:0] mem_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;

  // payload entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];
endmodule

FILE: sv/gnmc_div.sv
// four lane restoring divider for the group means, one quotient bit a cycle
// uses gnmc_pkg for the mean width and lane count
`timescale 1ns / 1ps
module gnmc_div #(
  parameter int SW    = 23,
  parameter int CNT_W = 7
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [gnmc_pkg::NUM_LANES-1:0][SW-1:0] num_i,
  input  logic [CNT_W-1:0] den_i,
  output logic done_o,
  output logic [gnmc_pkg::NUM_LANES-1:0][gnmc_pkg::MEAN_W-1:0] quot_o
);
  import gnmc_pkg::*;
  localparam int STW = $clog2(SW + 1);

  logic                 busy_q, done_q;
  logic [STW-1:0]       step_q;
  logic [CNT_W-1:0]     den_q;
  logic [NUM_LANES-1:0] neg_q;
  logic [NUM_LANES-1:0][SW-1:0]    quo_q;
  logic [NUM_LANES-1:0][CNT_W-1:0] rem_q;
  logic [NUM_LANES-1:0][SW-1:0]    quo_n;
  logic [NUM_LANES-1:0][CNT_W-1:0] rem_n;
  logic [CNT_W:0]       rem_sh, rem_sub;
  logic                 ge;
  logic signed [SW-1:0] res;

  // one shift and subtract step per lane
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      rem_sh   = {rem_q[k], quo_q[k][SW-1]};
      ge       = (rem_sh >= {1'b0, den_q});
      rem_sub  = rem_sh - {1'b0, den_q};
      rem_n[k] = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_n[k] = {quo_q[k][SW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STW'(1);
        if (step_q == STW'(SW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands and working values
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      for (int k = 0; k < NUM_LANES; k++) begin
        neg_q[k] <= num_i[k][SW-1];
        quo_q[k] <= num_i[k][SW-1] ? (SW'(0) - num_i[k]) : num_i[k];
        rem_q[k] <= '0;
      end
    end else if (busy_q) begin
      quo_q <= quo_n;
      rem_q <= rem_n;
    end
  end

  // restore sign, truncate toward zero
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      res       = neg_q[k] ? signed'(SW'(0) - quo_q[k]) : signed'(quo_q[k]);
      quot_o[k] = MEAN_W'(res);
    end
  end

  assign done_o = done_q;
endmodule

FILE: sv/gnmc_sqrt.sv
// iterative integer square root, one result bit a cycle, with a result hold
// uses gnmc_pkg for the tag type and distance width
`timescale 1ns / 1ps
module gnmc_sqrt #(
  parameter int SQ_W = 35
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic [SQ_W-1:0]     req_sq_i,
  input  gnmc_pkg::gnmc_tag_t req_tag_i,
  output logic                ready_o,
  output logic                res_valid_o,
  output logic [gnmc_pkg::DIST_W-1:0] res_root_o,
  output gnmc_pkg::gnmc_tag_t res_tag_o,
  input  logic                take_i
);
  import gnmc_pkg::*;
  localparam int STEPS = (SQ_W - 1) / 2 + 1;
  localparam int BIT0  = 2 * ((SQ_W - 1) / 2);
  localparam int STW   = $clog2(STEPS + 1);

  logic            busy_q, full_q;
  logic [STW-1:0]  step_q;
  logic [SQ_W-1:0] v_q, r_q, bit_q;
  gnmc_tag_t       tag_q;
  logic [SQ_W:0]   trial;
  logic            ge;

  assign trial = {1'b0, r_q} + {1'b0, bit_q};
  assign ge    = ({1'b0, v_q} >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      full_q <= 1'b0;
      step_q <= '0;
    end else begin
      if (req_valid_i && ready_o) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STW'(1);
        if (step_q == STW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          full_q <= 1'b1;
        end
      end
      if (take_i) begin
        full_q <= 1'b0;
      end
    end
  end

  // digit by digit root
  always_ff @(posedge clk_i) begin
    if (req_valid_i && ready_o) begin
      v_q   <= req_sq_i;
      r_q   <= '0;
      bit_q <= SQ_W'(1) << BIT0;
      tag_q <= req_tag_i;
    end else if (busy_q) begin
      if (ge) begin
        v_q <= v_q - trial[SQ_W-1:0];
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign ready_o     = !busy_q && !full_q;
  assign res_valid_o = full_q;
  assign res_root_o  = DIST_W'(r_q);
  assign res_tag_o   = tag_q;
endmodule

FILE: sv/gnmc_back.sv
// back end: per group means, then an all pairs scan for each member
// uses gnmc_pkg, gnmc_div; reads positions from the shared point ram
`timescale 1ns / 1ps
module gnmc_back #(
  parameter int MAX_MEMBERS = 64,
  parameter int COORD_BITS  = 16,
  localparam int IDXW  = $clog2(MAX_MEMBERS),
  localparam int AW    = IDXW + 1,
  localparam int CNT_W = $clog2(MAX_MEMBERS + 1),
  localparam int SW    = COORD_BITS + $clog2(MAX_MEMBERS) + 1,
  localparam int JW    = 1 + CNT_W + 4 * SW,
  localparam int DW    = COORD_BITS + 1,
  localparam int SQ_W  = (2 * COORD_BITS + 3 > 64) ? 64 : 2 * COORD_BITS + 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  logic [JW-1:0]       job_data_i,
  output logic                job_pop_o,
  output logic [AW-1:0]       ram_raddr_o,
  input  logic [2*COORD_BITS-1:0] ram_rdata_i,
  input  logic                sqrt_ready_i,
  output logic                req_valid_o,
  output logic [SQ_W-1:0]     req_sq_o,
  output gnmc_pkg::gnmc_tag_t req_tag_o,
  output logic                grp_done_o,
  output logic [gnmc_pkg::NUM_LANES-1:0][gnmc_pkg::MEAN_W-1:0] mean_o
);
  import gnmc_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE, B_DIV, B_ROW, B_PIVOT, B_SCAN, B_DRAIN, B_HAND
  } back_state_e;

  back_state_e      state_q;
  logic             bank_q;
  logic [CNT_W-1:0] n_q;
  logic [IDXW-1:0]  i_q, j_q, j1_q, j2_q, bidx_q;
  logic             v1_q, v2_q, found_q;
  logic signed [COORD_BITS-1:0] pix_q, piy_q;
  logic [SQ_W-1:0]  sqx_q, sqy_q, best_q;
  logic             start, div_done, row_last, col_last, better;
  logic [NUM_LANES-1:0][SW-1:0] nums;
  logic signed [COORD_BITS-1:0] xj, yj;
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]    adx, ady;
  logic [2*DW-1:0]  px, py;
  logic [SQ_W-1:0]  sq_sum;

  assign start    = (state_q == B_IDLE) && job_valid_i && sqrt_ready_i;
  assign nums     = job_data_i[4*SW-1:0];
  assign row_last = (CNT_W'(i_q) == n_q - CNT_W'(1));
  assign col_last = (CNT_W'(j_q) == n_q - CNT_W'(1));

  gnmc_div #(.SW(SW), .CNT_W(CNT_W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .num_i  (nums),
    .den_i  (job_data_i[JW-2 -: CNT_W]),
    .done_o (div_done),
    .quot_o (mean_o)
  );

  // pair distance: difference, magnitude and square
  always_comb begin
    xj  = ram_rdata_i[2*COORD_BITS-1:COORD_BITS];
    yj  = ram_rdata_i[COORD_BITS-1:0];
    dx  = DW'(xj) - DW'(pix_q);
    dy  = DW'(yj) - DW'(piy_q);
    adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
    px  = adx * adx;
    py  = ady * ady;
  end

  // sum and strict compare, so ties keep the lower index
  assign sq_sum = sqx_q + sqy_q;
  assign better = v2_q && (!found_q || (sq_sum < best_q));

  // handshakes toward queue, ram and root unit
  always_comb begin
    job_pop_o   = start;
    ram_raddr_o = {bank_q, (state_q == B_SCAN) ? j_q : i_q};
    req_valid_o = (state_q == B_HAND) && sqrt_ready_i;
    grp_done_o  = req_valid_o && row_last;
    req_sq_o    = best_q;
    req_tag_o.member   = IDX_OUT_W'(i_q);
    req_tag_o.mate     = found_q ? IDX_OUT_W'(bidx_q) : '0;
    req_tag_o.has_mate = found_q;
    req_tag_o.last     = row_last;
  end

  // sequencer and scan pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      v1_q <= (state_q == B_SCAN) && (j_q != i_q);
      v2_q <= v1_q;
      if (better) begin
        found_q <= 1'b1;
      end
      case (state_q)
        B_IDLE: begin
          if (start) begin
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          if (div_done) begin
            state_q <= B_ROW;
          end
        end
        B_ROW: begin
          state_q <= B_PIVOT;
        end
        B_PIVOT: begin
          found_q <= 1'b0;
          state_q <= B_SCAN;
        end
        B_SCAN: begin
          if (col_last) begin
            state_q <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          if (!v1_q && !v2_q) begin
            state_q <= B_HAND;
          end
        end
        B_HAND: begin
          if (sqrt_ready_i) begin
            state_q <= row_last ? B_IDLE : B_ROW;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  // group, index and distance registers
  always_ff @(posedge clk_i) begin
    j1_q  <= j_q;
    j2_q  <= j1_q;
    sqx_q <= SQ_W'(px);
    sqy_q <= SQ_W'(py);
    if (better) begin
      best_q <= sq_sum;
      bidx_q <= j2_q;
    end
    if (start) begin
      bank_q <= job_data_i[JW-1];
      n_q    <= job_data_i[JW-2 -: CNT_W];
      i_q    <= '0;
    end
    if (state_q == B_PIVOT) begin
      pix_q <= xj;
      piy_q <= yj;
      j_q   <= '0;
    end
    if (state_q == B_SCAN && !col_last) begin
      j_q <= j_q + IDXW'(1);
    end
    if (state_q == B_HAND && sqrt_ready_i && !row_last) begin
      i_q <= i_q + IDXW'(1);
    end
  end
endmodule

FILE: sv/group_nearest_mate_and_centroid_unit.sv
// top level of the nearest mate and centroid unit
// uses gnmc_pkg, gnmc_front, gnmc_queue, gnmc_back, gnmc_sqrt, gnmc_ram
//
// usage: members arrive on the input channel (valid/stall), one per transfer,
// position and velocity in signed Q12.4; last_member closes the group. The
// group then yields one result per member on the output channel, in load
// order, with last_result on the final one. The lone member of a group has
// has_mate low and an all ones distance.
// after the closing transfer the means are computed in the shared divider;
// each member then takes one row scan, one pair per cycle over the single
// read port of the point ram, with its root overlapped by the next row;
// below 14 members the root unit sets the pace instead.
// positions sit in two ram banks: the front end loads the next group while
// the back end works on the previous one, and stalls input while two
// closed groups are held.
// reset clears all control state; ram contents are not cleared. a stalled
// output holds its result, and the root unit and scan then wait behind it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module group_nearest_mate_and_centroid_unit #(
  parameter int MAX_MEMBERS = 64,
  parameter int COORD_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] pos_x_i,
  input  logic [COORD_BITS-1:0] pos_y_i,
  input  logic [COORD_BITS-1:0] vel_x_i,
  input  logic [COORD_BITS-1:0] vel_y_i,
  input  logic                  last_member_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [gnmc_pkg::IDX_OUT_W-1:0] member_index_o,
  output logic [gnmc_pkg::IDX_OUT_W-1:0] mate_index_o,
  output logic                  has_mate_o,
  output logic [gnmc_pkg::DIST_W-1:0] distance_o,
  output logic [gnmc_pkg::MEAN_W-1:0] center_x_o,
  output logic [gnmc_pkg::MEAN_W-1:0] center_y_o,
  output logic [gnmc_pkg::MEAN_W-1:0] heading_x_o,
  output logic [gnmc_pkg::MEAN_W-1:0] heading_y_o,
  output logic                  last_result_o
);
  import gnmc_pkg::*;
  localparam int IDXW  = $clog2(MAX_MEMBERS);
  localparam int AW    = IDXW + 1;
  localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
  localparam int SW    = COORD_BITS + $clog2(MAX_MEMBERS) + 1;
  localparam int JW    = 1 + CNT_W + 4 * SW;
  localparam int SQ_W  = (2 * COORD_BITS + 3 > 64) ? 64 : 2 * COORD_BITS + 3;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [2*COORD_BITS-1:0] ram_wdata, ram_rdata;
  logic                    job_push, job_pop, job_valid;
  logic [JW-1:0]           job_in, job_out;
  logic                    grp_done, banks_full;
  logic [1:0]              inuse_q;
  logic                    req_valid, sqrt_ready, sq_valid, sq_take;
  logic [SQ_W-1:0]         req_sq;
  gnmc_tag_t               req_tag, sq_tag;
  logic [DIST_W-1:0]       sq_root;
  logic [NUM_LANES-1:0][MEAN_W-1:0] means;

  logic              out_valid_q;
  gnmc_tag_t         out_tag_q;
  logic [DIST_W-1:0] out_dist_q;
  logic [NUM_LANES-1:0][MEAN_W-1:0] out_mean_q;

  gnmc_ram #(.WIDTH(2 * COORD_BITS), .DEPTH(2 ** AW)) u_points (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  gnmc_front #(.MAX_MEMBERS(MAX_MEMBERS), .COORD_BITS(COORD_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .vel_x_i      (vel_x_i),
    .vel_y_i      (vel_y_i),
    .last_member_i(last_member_i),
    .banks_full_i (banks_full),
    .ram_we_o     (ram_we),
    .ram_addr_o   (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .job_push_o   (job_push),
    .job_data_o   (job_in)
  );

  gnmc_queue #(.W(JW)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .pop_i  (job_pop),
    .valid_o(job_valid),
    .data_o (job_out)
  );

  gnmc_back #(.MAX_MEMBERS(MAX_MEMBERS), .COORD_BITS(COORD_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_data_i  (job_out),
    .job_pop_o   (job_pop),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .sqrt_ready_i(sqrt_ready),
    .req_valid_o (req_valid),
    .req_sq_o    (req_sq),
    .req_tag_o   (req_tag),
    .grp_done_o  (grp_done),
    .mean_o      (means)
  );

  gnmc_sqrt #(.SQ_W(SQ_W)) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_sq_i   (req_sq),
    .req_tag_i  (req_tag),
    .ready_o    (sqrt_ready),
    .res_valid_o(sq_valid),
    .res_root_o (sq_root),
    .res_tag_o  (sq_tag),
    .take_i     (sq_take)
  );

  // point ram banks holding closed groups
  assign banks_full = (inuse_q == 2'd2);
  assign sq_take    = sq_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inuse_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      inuse_q <= inuse_q + 2'(job_push) - 2'(grp_done);
      if (sq_take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (sq_take) begin
      out_tag_q  <= sq_tag;
      out_dist_q <= sq_tag.has_mate ? sq_root : NO_MATE_DIST;
      out_mean_q <= means;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign member_index_o = out_tag_q.member;
  assign mate_index_o   = out_tag_q.mate;
  assign has_mate_o     = out_tag_q.has_mate;
  assign distance_o     = out_dist_q;
  assign center_x_o     = out_mean_q[3];
  assign center_y_o     = out_mean_q[2];
  assign heading_x_o    = out_mean_q[1];
  assign heading_y_o    = out_mean_q[0];
  assign last_result_o  = out_tag_q.last;

  `GNMC_NEVER(a_bank_over, clk_i, rst_ni, inuse_q == 2'd3, "more than two groups held")
  `GNMC_ASSERT(a_push_room, clk_i, rst_ni, job_push |-> inuse_q != 2'd2, "group closed with no bank free")
  `GNMC_ASSERT(a_done_held, clk_i, rst_ni, grp_done |-> inuse_q != 2'd0, "group released with no bank held")
  `GNMC_ASSERT(a_take_loads, clk_i, rst_ni, sq_take |=> out_valid_q, "root result lost")
endmodule
